>>> hdl/hns_pkg.sv
package hns_pkg;

  localparam int MAX_SIZE = 1024;
  localparam int ADDR_W   = $clog2(MAX_SIZE);
  localparam int GRID_W   = 11;
  localparam logic [GRID_W-1:0] GRID_RESET = 11'd256;
  localparam logic [GRID_W-1:0] MIN_SIZE   = 11'd3;

  localparam int HGT_W  = 16;
  localparam int DIFF_W = HGT_W + 1;
  localparam int MAG_W  = HGT_W;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int S_W    = SQ_W + 2;
  localparam int ACC_W  = 69;

  // Output field widths.
  localparam int POS_W = 10;
  localparam int NX_W  = 16;
  localparam int NY_W  = 15;
  localparam int Q_W   = 15;
  localparam int ITER_W = $clog2(Q_W);

  // The vertical difference is 2.0 in Q8.8, and the bound carries 2^30 = (2 * 2^14)^2.
  localparam int TWO_Q   = 512;
  localparam int R_SHIFT = 30;
  localparam logic [S_W-1:0] TWO_SQ = S_W'(TWO_Q * TWO_Q);
  localparam logic signed [ACC_W-1:0] R_Y = ACC_W'(TWO_Q * TWO_Q) << R_SHIFT;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_DIFF = 6'b000100,
    S_SQR  = 6'b001000,
    S_ITER = 6'b010000,
    S_EMIT = 6'b100000
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] ci;
    logic [ADDR_W-1:0] col;
    logic [ADDR_W-1:0] nm1;
    logic              row_first;
    logic              row_last;
    logic              col_first;
    logic              col_last;
  } pos_t;

  typedef struct packed {
    logic load;
    logic bank;
    pos_t pos;
    logic diff;
    logic square;
    logic init;
    logic step;
    logic emit_start;
    logic emit_next;
  } cmd_t;

  typedef struct packed {
    logic iter_last;
    logic emit_last;
  } status_t;

endpackage

>>> hdl/hns_height_if.sv
interface hns_height_if;
  logic                                valid;
  logic                                ready;
  logic signed [hns_pkg::HGT_W-1:0]    height;

  modport source (output valid, output height, input ready);
  modport sink   (input valid, input height, output ready);
endinterface

>>> hdl/hns_normal_if.sv
interface hns_normal_if;
  logic                               valid;
  logic                               ready;
  logic [hns_pkg::POS_W-1:0]          row;
  logic [hns_pkg::POS_W-1:0]          column;
  logic signed [hns_pkg::NX_W-1:0]    normal_x;
  logic [hns_pkg::NY_W-1:0]           normal_y;
  logic signed [hns_pkg::NX_W-1:0]    normal_z;
  logic                               last;

  modport source (output valid, output row, output column, output normal_x,
                  output normal_y, output normal_z, output last, input ready);
  modport sink   (input valid, input row, input column, input normal_x,
                  input normal_y, input normal_z, input last, output ready);
endinterface

>>> hdl/hns_ram.sv
module hns_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

>>> hdl/hns_datapath.sv
module hns_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  hns_pkg::cmd_t                    cmd_i,
  input  logic signed [hns_pkg::HGT_W-1:0] height_i,
  output hns_pkg::status_t                 status_o,
  output logic [hns_pkg::POS_W-1:0]        row_o,
  output logic [hns_pkg::POS_W-1:0]        column_o,
  output logic signed [hns_pkg::NX_W-1:0]  normal_x_o,
  output logic [hns_pkg::NY_W-1:0]         normal_y_o,
  output logic signed [hns_pkg::NX_W-1:0]  normal_z_o,
  output logic                             last_o
);

  localparam int AW = hns_pkg::ADDR_W;
  localparam int ACC_W = hns_pkg::ACC_W;

  // Row buffers: the bank index names the newer row, the other bank is written.
  logic [AW-1:0] addr_c, addr_m, addr_p;
  logic [hns_pkg::HGT_W-1:0] rd_a0, rd_a1, rd_b0, rd_b1;

  assign addr_c = cmd_i.pos.col;
  assign addr_m = cmd_i.pos.col - AW'(1);
  assign addr_p = cmd_i.pos.col + AW'(1);

  hns_ram #(.WIDTH(hns_pkg::HGT_W), .DEPTH(hns_pkg::MAX_SIZE)) u_ram_a (
    .clk_i    (clk_i),
    .we_i     (cmd_i.load && cmd_i.bank),
    .waddr_i  (addr_c),
    .wdata_i  (height_i),
    .raddr0_i (cmd_i.bank ? addr_c : addr_m),
    .raddr1_i (addr_p),
    .rdata0_o (rd_a0),
    .rdata1_o (rd_a1)
  );

  hns_ram #(.WIDTH(hns_pkg::HGT_W), .DEPTH(hns_pkg::MAX_SIZE)) u_ram_b (
    .clk_i    (clk_i),
    .we_i     (cmd_i.load && !cmd_i.bank),
    .waddr_i  (addr_c),
    .wdata_i  (height_i),
    .raddr0_i (cmd_i.bank ? addr_m : addr_c),
    .raddr1_i (addr_p),
    .rdata0_o (rd_b0),
    .rdata1_o (rd_b1)
  );

  logic                              bank_q;
  hns_pkg::pos_t                     pos_q;
  logic signed [hns_pkg::HGT_W-1:0]  hd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bank_q <= cmd_i.bank;
      pos_q  <= cmd_i.pos;
      hd_q   <= height_i;
    end
  end

  logic signed [hns_pkg::HGT_W-1:0] hl, hr, hu;
  assign hl = bank_q ? rd_b0 : rd_a0;
  assign hr = bank_q ? rd_b1 : rd_a1;
  assign hu = bank_q ? rd_a0 : rd_b0;

  logic signed [hns_pkg::DIFF_W-1:0] dx_q, dz_q;
  logic [hns_pkg::MAG_W-1:0]         magx, magz;
  logic [hns_pkg::SQ_W-1:0]          sqx_q, sqz_q;
  logic                              negx_q, negz_q;

  assign magx = hns_pkg::MAG_W'(dx_q[hns_pkg::DIFF_W-1] ? -dx_q : dx_q);
  assign magz = hns_pkg::MAG_W'(dz_q[hns_pkg::DIFF_W-1] ? -dz_q : dz_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      dx_q <= {hl[hns_pkg::HGT_W-1], hl} - {hr[hns_pkg::HGT_W-1], hr};
      dz_q <= {hd_q[hns_pkg::HGT_W-1], hd_q} - {hu[hns_pkg::HGT_W-1], hu};
    end
    if (cmd_i.square) begin
      sqx_q  <= {{hns_pkg::MAG_W{1'b0}}, magx} * {{hns_pkg::MAG_W{1'b0}}, magx};
      sqz_q  <= {{hns_pkg::MAG_W{1'b0}}, magz} * {{hns_pkg::MAG_W{1'b0}}, magz};
      negx_q <= dx_q[hns_pkg::DIFF_W-1];
      negz_q <= dz_q[hns_pkg::DIFF_W-1];
    end
  end

  // Bit-serial search for the largest q with (2q-1)^2 * s <= 2^30 * v^2.
  // Per lane, e holds (2q-1)^2 * s, f holds (2q-1) * s * 2^(k+2) and the shared
  // term ss holds s * 2^(2k+2), so each trial bit is two adds and a compare.
  logic [hns_pkg::S_W-1:0]  s_sum;
  logic signed [ACC_W-1:0]  s_ext;
  logic signed [ACC_W-1:0]  ss_q, ss_d;
  logic signed [ACC_W-1:0]  e_q [3];
  logic signed [ACC_W-1:0]  e_d [3];
  logic signed [ACC_W-1:0]  f_q [3];
  logic signed [ACC_W-1:0]  f_d [3];
  logic signed [ACC_W-1:0]  r_q [3];
  logic [hns_pkg::Q_W-1:0]  q_q [3];
  logic [hns_pkg::Q_W-1:0]  q_d [3];
  logic [hns_pkg::ITER_W-1:0] k_q;

  assign s_sum = hns_pkg::S_W'(sqx_q) + hns_pkg::S_W'(sqz_q) + hns_pkg::TWO_SQ;
  assign s_ext = ACC_W'(s_sum);
  assign ss_d  = ss_q >>> 2;

  always_comb begin
    logic signed [ACC_W-1:0] cand;
    logic                    ok;
    for (int i = 0; i < 3; i++) begin
      cand   = e_q[i] + f_q[i] + ss_q;
      ok     = (cand <= r_q[i]);
      e_d[i] = ok ? cand : e_q[i];
      f_d[i] = (ok ? f_q[i] + (ss_q <<< 1) : f_q[i]) >>> 1;
      q_d[i] = {q_q[i][hns_pkg::Q_W-2:0], ok};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      ss_q <= s_ext <<< (2 * hns_pkg::Q_W);
      r_q[0] <= ACC_W'(sqx_q) <<< hns_pkg::R_SHIFT;
      r_q[1] <= hns_pkg::R_Y;
      r_q[2] <= ACC_W'(sqz_q) <<< hns_pkg::R_SHIFT;
      for (int i = 0; i < 3; i++) begin
        e_q[i] <= s_ext;
        f_q[i] <= -(s_ext <<< (hns_pkg::Q_W + 1));
        q_q[i] <= '0;
      end
    end else if (cmd_i.step) begin
      ss_q <= ss_d;
      for (int i = 0; i < 3; i++) begin
        e_q[i] <= e_d[i];
        f_q[i] <= f_d[i];
        q_q[i] <= q_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.init) begin
      k_q <= hns_pkg::ITER_W'(hns_pkg::Q_W - 1);
    end else if (cmd_i.step) begin
      k_q <= k_q - hns_pkg::ITER_W'(1);
    end
  end

  // Border positions: row 0 and column 0 precede the centre, the last row and
  // column follow it.
  logic [AW-1:0] row_q, col_q;
  logic          row_more, col_more;
  logic [AW-1:0] row_start, col_start;

  assign row_start = pos_q.row_first ? '0 : pos_q.ci;
  assign col_start = pos_q.col_first ? '0 : pos_q.col;
  assign col_more  = (col_q == '0) || (col_q == pos_q.col && pos_q.col_last);
  assign row_more  = (row_q == '0) || (row_q == pos_q.ci && pos_q.row_last);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_start) begin
      row_q <= row_start;
      col_q <= col_start;
    end else if (cmd_i.emit_next) begin
      if (col_more) begin
        col_q <= (col_q == '0) ? pos_q.col : pos_q.nm1;
      end else if (row_more) begin
        row_q <= (row_q == '0) ? pos_q.ci : pos_q.nm1;
        col_q <= col_start;
      end
    end
  end

  assign status_o.iter_last = (k_q == '0);
  assign status_o.emit_last = !col_more && !row_more;

  assign row_o      = hns_pkg::POS_W'(row_q);
  assign column_o   = hns_pkg::POS_W'(col_q);
  assign normal_x_o = negx_q ? -{1'b0, q_q[0]} : {1'b0, q_q[0]};
  assign normal_y_o = q_q[1];
  assign normal_z_o = negz_q ? -{1'b0, q_q[2]} : {1'b0, q_q[2]};
  assign last_o     = !col_more && !row_more;

endmodule

>>> hdl/hns_ctrl.sv
module hns_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hns_pkg::GRID_W-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  input  hns_pkg::status_t             status_i,
  output hns_pkg::cmd_t                cmd_o
);

  localparam int AW = hns_pkg::ADDR_W;
  localparam int GW = hns_pkg::GRID_W;

  hns_pkg::state_e    state_q, state_d;
  logic [GW-1:0]      grid_q, grid_d;
  logic [AW-1:0]      row_q, row_d, col_q, col_d;
  logic               bank_q, bank_d;
  logic [GW-1:0]      n_eff;
  logic [GW-1:0]      col_ext, row_ext;
  logic               accept, centre;

  always_comb begin
    if (grid_q < hns_pkg::MIN_SIZE) begin
      n_eff = hns_pkg::MIN_SIZE;
    end else if (grid_q > GW'(hns_pkg::MAX_SIZE)) begin
      n_eff = GW'(hns_pkg::MAX_SIZE);
    end else begin
      n_eff = grid_q;
    end
  end

  assign col_ext = GW'(col_q);
  assign row_ext = GW'(row_q);
  assign accept  = in_valid_i && in_ready_o;
  assign centre  = (row_q >= AW'(2)) && (col_q >= AW'(1)) && (col_ext + GW'(2) <= n_eff);

  always_comb begin
    cmd_o                   = '0;
    cmd_o.load              = accept;
    cmd_o.bank              = bank_q;
    cmd_o.pos.ci            = row_q - AW'(1);
    cmd_o.pos.col           = col_q;
    cmd_o.pos.nm1           = AW'(n_eff - GW'(1));
    cmd_o.pos.row_first     = (row_q == AW'(2));
    cmd_o.pos.row_last      = (row_ext == n_eff - GW'(1));
    cmd_o.pos.col_first     = (col_q == AW'(1));
    cmd_o.pos.col_last      = (col_ext == n_eff - GW'(2));
    in_ready_o              = 1'b0;
    out_valid_o             = 1'b0;
    state_d                 = state_q;
    unique case (state_q)
      hns_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (accept && centre) begin
          state_d = hns_pkg::S_READ;
        end
      end
      hns_pkg::S_READ: begin
        cmd_o.diff = 1'b1;
        state_d    = hns_pkg::S_DIFF;
      end
      hns_pkg::S_DIFF: begin
        cmd_o.square = 1'b1;
        state_d      = hns_pkg::S_SQR;
      end
      hns_pkg::S_SQR: begin
        cmd_o.init = 1'b1;
        state_d    = hns_pkg::S_ITER;
      end
      hns_pkg::S_ITER: begin
        cmd_o.step = 1'b1;
        if (status_i.iter_last) begin
          cmd_o.emit_start = 1'b1;
          state_d          = hns_pkg::S_EMIT;
        end
      end
      hns_pkg::S_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.emit_next = 1'b1;
          if (status_i.emit_last) begin
            state_d = hns_pkg::S_IDLE;
          end
        end
      end
      default: state_d = hns_pkg::S_IDLE;
    endcase
  end

  // Raster position of the next sample; the banks swap at the end of each row.
  always_comb begin
    grid_d = grid_q;
    row_d  = row_q;
    col_d  = col_q;
    bank_d = bank_q;
    if (cfg_we_i) begin
      grid_d = cfg_data_i;
      row_d  = '0;
      col_d  = '0;
    end else if (accept) begin
      if (col_ext + GW'(1) >= n_eff) begin
        col_d  = '0;
        bank_d = !bank_q;
        row_d  = (row_ext + GW'(1) >= n_eff) ? '0 : row_q + AW'(1);
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hns_pkg::S_IDLE;
      grid_q  <= hns_pkg::GRID_RESET;
      row_q   <= '0;
      col_q   <= '0;
      bank_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      grid_q  <= grid_d;
      row_q   <= row_d;
      col_q   <= col_d;
      bank_q  <= bank_d;
    end
  end

  a_centre_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && centre |=> state_q == hns_pkg::S_READ)
    else $error("centre transaction did not start the normal computation");

  a_iter_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hns_pkg::S_ITER && !status_i.iter_last |=> state_q == hns_pkg::S_ITER)
    else $error("normalizer left before its last bit");

  a_no_accept_while_emitting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while results are pending");

  a_position_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_ext < n_eff && row_ext < n_eff)
    else $error("raster position outside the grid");

endmodule

>>> hdl/heightmap_normal_stream.sv
// Samples without a complete centre are taken one per cycle and give no result.
// A sample that completes a centre gives its first result after the buffer read,
// difference, square and 15-bit serial normalizer, then one result per cycle
// while the output is ready, up to nine; the next sample is taken after the last one.
// Reset sets grid_size to 256 and the position to (0, 0); row buffers are not cleared.
module heightmap_normal_stream (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [hns_pkg::GRID_W-1:0] cfg_data_i,
  hns_height_if.sink                 height_i,
  hns_normal_if.source               normal_o
);

  hns_pkg::cmd_t    cmd;
  hns_pkg::status_t status;

  hns_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (height_i.valid),
    .in_ready_o  (height_i.ready),
    .out_valid_o (normal_o.valid),
    .out_ready_i (normal_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  hns_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .height_i   (height_i.height),
    .status_o   (status),
    .row_o      (normal_o.row),
    .column_o   (normal_o.column),
    .normal_x_o (normal_o.normal_x),
    .normal_y_o (normal_o.normal_y),
    .normal_z_o (normal_o.normal_z),
    .last_o     (normal_o.last)
  );

endmodule
